// ===== rtl/jws_pkg.sv =====
// Shared types and constants for the Jaro-Winkler similarity block.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package jws_pkg;

  // Input opcodes carried in s_axis_tuser
  localparam logic [1:0] OPC_FIRST   = 2'd0;
  localparam logic [1:0] OPC_SECOND  = 2'd1;
  localparam logic [1:0] OPC_COMPUTE = 2'd2;
  localparam logic [1:0] OPC_RSVD    = 2'd3;

  localparam int OPC_W      = 2;
  localparam int CHAR_W     = 21;
  localparam int LIMIT_W    = 7;
  localparam int SIM_W      = 17;
  localparam int MATCH_W    = 7;
  localparam int TRANS_W    = 6;
  localparam int PREFIX_W   = 7;
  localparam int RES_W      = SIM_W + MATCH_W + TRANS_W + PREFIX_W + 1;
  localparam int IN_TDATA_W = 24;
  localparam int OUT_TDATA_W = 40;
  localparam int FRAC_BITS  = 16;

  // floor(x / 10) as (x * BONUS_RECIP) >> BONUS_SHIFT, exact for x below 2^23
  localparam logic [22:0] BONUS_RECIP = 23'd6710887;
  localparam int          BONUS_SHIFT = 26;

  localparam logic [SIM_W-1:0] SIM_ONE = 17'h10000;

  // Datapath operations issued by the controller
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_INIT,
    OP_RD_IDX,
    OP_IDX_INC,
    OP_SAME,
    OP_SRC_RD,
    OP_SRC_LATCH,
    OP_DST_RD,
    OP_POS_INC,
    OP_HIT,
    OP_SIDE_DONE,
    OP_ROUND,
    OP_ZERO,
    OP_MUL1,
    OP_MUL2,
    OP_MUL3,
    OP_DJ_GO,
    OP_SIM_J,
    OP_IDX_CLR,
    OP_PFX_INC,
    OP_BMUL,
    OP_DB_GO,
    OP_BADD,
    OP_EMIT
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic both_nonempty;
    logic same_len;
    logic idx_lt_l1;
    logic rd_eq;
    logic sd;
    logic pos_end;
    logic idx_ge_hi;
    logic idx_used;
    logic dst_eq;
    logic v1;
    logic v2;
    logic more;
    logic m_zero;
    logic limit_zero;
    logic pfx_go;
    logic div_done;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/jaro_winkler_similarity.sv =====
// Top level of the Jaro-Winkler similarity block: stream ports and output register.
// Depends on jws_pkg, jws_ctrl and jws_datapath.
//
//  channel   dir  handshake                  contents
//  s_axis    in   s_axis_tvalid/tready       tuser: opcode; tdata: char_code
//  m_axis    out  m_axis_tvalid/tready       tdata: score, counts, overflow flag
//  cfg       in   cfg_valid_i/cfg_ready_o    cfg_data_i: prefix_limit
//
// A compute beat on two non-empty strings runs an equality pass when the lengths match
// (an identical pair ends there), the windowed match scan in rounds, one restoring
// division if any match is left, and, when prefix_limit is nonzero, a prefix pass and
// the bonus.
// Reset clears lengths, used flags, overflow and prefix_limit; stores need no clearing.
// A finished result waits in the output register while new loads are accepted.
`timescale 1ns / 1ps
`default_nettype none

module jaro_winkler_similarity #(
  parameter int MAX_LEN   = 64,
  parameter int CHAR_BITS = 21
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  // [20:0] char_code
  input  wire logic [jws_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // [1:0] opcode
  input  wire logic [jws_pkg::OPC_W-1:0]          s_axis_tuser,
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  // [16:0] similarity, [23:17] match_count, [29:24] transposition_count,
  // [36:30] prefix_count, [37] overflow
  output logic [jws_pkg::OUT_TDATA_W-1:0]         m_axis_tdata,
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [jws_pkg::LIMIT_W-1:0]        cfg_data_i
);

  jws_pkg::dp_cmd_t    cmd;
  jws_pkg::dp_status_t status;
  logic [jws_pkg::RES_W-1:0] res;
  logic                      out_valid_q;
  logic [jws_pkg::RES_W-1:0] out_data_q;
  logic                      out_free;
  logic                      in_ready;

  assign out_free    = !out_valid_q || m_axis_tready;
  assign cfg_ready_o = 1'b1;

  jws_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .opcode_i  (s_axis_tuser),
    .out_free_i(out_free),
    .status_i  (status),
    .in_ready_o(in_ready),
    .cmd_o     (cmd)
  );

  jws_datapath #(
    .MAX_LEN  (MAX_LEN),
    .CHAR_BITS(CHAR_BITS)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .opcode_i  (s_axis_tuser),
    .char_i    (s_axis_tdata[jws_pkg::CHAR_W-1:0]),
    .cfg_we_i  (cfg_valid_i),
    .cfg_data_i(cfg_data_i),
    .status_o  (status),
    .res_o     (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd.op == jws_pkg::OP_EMIT) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd.op == jws_pkg::OP_EMIT) begin
      out_data_q <= res;
    end
  end

  assign s_axis_tready = in_ready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = jws_pkg::OUT_TDATA_W'(out_data_q);

endmodule

`default_nettype wire

// ===== rtl/jws_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Used by jws_datapath for the Jaro score.
`timescale 1ns / 1ps
`default_nettype none

module jws_div #(
  parameter int W = 39
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start_i,
  input  wire logic [W-1:0] dividend_i,
  input  wire logic [W-1:0] divisor_i,
  output logic              done_o,
  output logic [W-1:0]      quot_o
);

  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  x_q, x_d;
  logic [W-1:0]  rem_q, rem_d;
  logic [W-1:0]  den_q;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [W:0]    trial;
  logic          fits;

  assign trial = {rem_q, x_q[W-1]};
  assign fits  = (trial >= {1'b0, den_q});

  always_comb begin
    x_d    = x_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      x_d    = dividend_i;
      rem_d  = '0;
      cnt_d  = CW'(W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      // shift the next dividend bit in, subtract where it fits
      rem_d = fits ? W'(trial - {1'b0, den_q}) : trial[W-1:0];
      x_d   = {x_q[W-2:0], fits};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    rem_q <= rem_d;
    if (start_i) begin
      den_q <= divisor_i;
    end
  end

  assign done_o = done_q;
  assign quot_o = x_q;

endmodule

`default_nettype wire

// ===== rtl/jws_datapath.sv =====
// Datapath: character stores, scan counters, used flags, arithmetic and result.
// Depends on jws_pkg and jws_div; driven by commands from jws_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module jws_datapath #(
  parameter int MAX_LEN   = 64,
  parameter int CHAR_BITS = 21
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire jws_pkg::dp_cmd_t              cmd_i,
  input  wire logic [jws_pkg::OPC_W-1:0]     opcode_i,
  input  wire logic [jws_pkg::CHAR_W-1:0]    char_i,
  input  wire logic                          cfg_we_i,
  input  wire logic [jws_pkg::LIMIT_W-1:0]   cfg_data_i,
  output jws_pkg::dp_status_t                status_o,
  output logic [jws_pkg::RES_W-1:0]          res_o
);

  localparam int LW  = $clog2(MAX_LEN + 1);
  localparam int AW  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int MW  = (CHAR_BITS < jws_pkg::CHAR_W) ? CHAR_BITS : jws_pkg::CHAR_W;
  localparam int NW  = 3 * LW + 2;
  localparam int DW  = NW + jws_pkg::FRAC_BITS;
  localparam int PW  = LW + jws_pkg::SIM_W;
  localparam int XW  = (LW > jws_pkg::LIMIT_W) ? LW : jws_pkg::LIMIT_W;
  localparam int MMW = 2 * LW;
  // bonus product stays below 2^23 since the prefix count never exceeds 127
  localparam int QW  = 23;
  localparam int BW  = 2 * QW - jws_pkg::BONUS_SHIFT;

  logic [MW-1:0] mem1 [MAX_LEN];
  logic [MW-1:0] mem2 [MAX_LEN];
  logic [MW-1:0] rd1_q, rd2_q;
  logic [AW-1:0] a1, a2;

  logic [LW-1:0] l1_q, l2_q, p1_q, p2_q, idx_q, hi_q, h_q;
  logic [LW-1:0] m_q, t_q, pc_q;
  logic [MAX_LEN-1:0] used1_q, used2_q;
  logic          ovf_q, sd_q, v1_q, v2_q;
  logic [MW-1:0] c_q, c1_q, c2_q;
  logic [jws_pkg::LIMIT_W-1:0] limit_q;
  logic [jws_pkg::SIM_W-1:0]   sim_q;

  logic [MMW-1:0]  mm_q, ab_q;
  logic [NW-1:0]   s1_q, s2_q, dn_q, num_q, den_q;
  logic [PW-1:0]   prod_q;
  logic [BW-1:0]   bonus_q;

  logic [LW-1:0] pos, slen, dlen, lo, hi, h1, h2;
  logic [LW:0]   hsum;
  logic [MW-1:0] src_data, dst_data;
  logic [MW-1:0] ch;
  logic [XW-1:0] pc_x, lim_x, l1_x, l2_x, m_x, t_x;

  logic          div_start, div_done;
  logic [DW-1:0] div_num, div_den, quot;
  logic [2*QW-1:0] bprod;
  logic [BW:0]   bsum;
  logic          is_load;

  jws_div #(.W(DW)) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_num),
    .divisor_i (div_den),
    .done_o    (div_done),
    .quot_o    (quot)
  );

  assign ch       = char_i[MW-1:0];
  assign pos      = sd_q ? p2_q : p1_q;
  assign slen     = sd_q ? l2_q : l1_q;
  assign dlen     = sd_q ? l1_q : l2_q;
  assign src_data = sd_q ? rd2_q : rd1_q;
  assign dst_data = sd_q ? rd1_q : rd2_q;
  assign lo       = (h_q > pos) ? '0 : LW'(pos - h_q);
  assign hsum     = {1'b0, pos} + {1'b0, h_q};
  assign hi       = (hsum > {1'b0, dlen}) ? dlen : hsum[LW-1:0];
  assign h1       = LW'((l1_q >> 1) + 1'b1);
  assign h2       = LW'((l2_q >> 1) + 1'b1);

  assign div_start = (cmd_i.op == jws_pkg::OP_DJ_GO);
  assign div_num   = {num_q, {jws_pkg::FRAC_BITS{1'b0}}};
  assign div_den   = DW'(den_q);
  // divide the bonus product by ten through the reciprocal
  assign bprod     = (2 * QW)'(QW'(prod_q)) * (2 * QW)'(jws_pkg::BONUS_RECIP);
  assign bsum      = (BW + 1)'(sim_q) + (BW + 1)'(bonus_q);

  assign is_load = (cmd_i.op == jws_pkg::OP_LOAD);

  // Read address selection for the two character stores
  always_comb begin
    a1 = idx_q[AW-1:0];
    a2 = idx_q[AW-1:0];
    case (cmd_i.op)
      jws_pkg::OP_SRC_RD: begin
        a1 = p1_q[AW-1:0];
        a2 = p2_q[AW-1:0];
      end
      default: begin
        a1 = idx_q[AW-1:0];
        a2 = idx_q[AW-1:0];
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (is_load && opcode_i == jws_pkg::OPC_FIRST && l1_q < LW'(MAX_LEN)) begin
      mem1[l1_q[AW-1:0]] <= ch;
    end
    rd1_q <= mem1[a1];
  end

  always_ff @(posedge clk_i) begin
    if (is_load && opcode_i == jws_pkg::OPC_SECOND && l2_q < LW'(MAX_LEN)) begin
      mem2[l2_q[AW-1:0]] <= ch;
    end
    rd2_q <= mem2[a2];
  end

  // Control-side registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      l1_q    <= '0;
      l2_q    <= '0;
      ovf_q   <= 1'b0;
      used1_q <= '0;
      used2_q <= '0;
      limit_q <= '0;
      p1_q    <= '0;
      p2_q    <= '0;
      idx_q   <= '0;
      sd_q    <= 1'b0;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        limit_q <= cfg_data_i;
      end
      unique case (cmd_i.op)
        jws_pkg::OP_LOAD: begin
          if (opcode_i == jws_pkg::OPC_FIRST) begin
            if (l1_q < LW'(MAX_LEN)) l1_q <= l1_q + 1'b1;
            else                     ovf_q <= 1'b1;
          end else begin
            if (l2_q < LW'(MAX_LEN)) l2_q <= l2_q + 1'b1;
            else                     ovf_q <= 1'b1;
          end
        end
        jws_pkg::OP_INIT: begin
          p1_q  <= '0;
          p2_q  <= '0;
          idx_q <= '0;
          sd_q  <= 1'b0;
          v1_q  <= 1'b0;
          v2_q  <= 1'b0;
        end
        jws_pkg::OP_IDX_INC: idx_q <= idx_q + 1'b1;
        jws_pkg::OP_SRC_LATCH: idx_q <= lo;
        jws_pkg::OP_POS_INC: begin
          if (sd_q) p2_q <= p2_q + 1'b1;
          else      p1_q <= p1_q + 1'b1;
        end
        jws_pkg::OP_HIT: begin
          if (sd_q) begin
            used1_q[idx_q[AW-1:0]] <= 1'b1;
            p2_q <= p2_q + 1'b1;
            v2_q <= 1'b1;
          end else begin
            used2_q[idx_q[AW-1:0]] <= 1'b1;
            p1_q <= p1_q + 1'b1;
            v1_q <= 1'b1;
          end
          sd_q <= ~sd_q;
        end
        jws_pkg::OP_SIDE_DONE: sd_q <= ~sd_q;
        jws_pkg::OP_ROUND: begin
          v1_q <= 1'b0;
          v2_q <= 1'b0;
          sd_q <= 1'b0;
        end
        jws_pkg::OP_IDX_CLR: idx_q <= '0;
        jws_pkg::OP_PFX_INC: idx_q <= idx_q + 1'b1;
        jws_pkg::OP_EMIT: begin
          l1_q    <= '0;
          l2_q    <= '0;
          ovf_q   <= 1'b0;
          used1_q <= '0;
          used2_q <= '0;
        end
        default: ;
      endcase
    end
  end

  // Payload registers: scan characters, counts and arithmetic
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      jws_pkg::OP_INIT: begin
        h_q   <= (h1 < h2) ? h1 : h2;
        m_q   <= '0;
        t_q   <= '0;
        pc_q  <= '0;
        sim_q <= '0;
      end
      jws_pkg::OP_SAME: begin
        sim_q <= jws_pkg::SIM_ONE;
        m_q   <= l1_q;
      end
      jws_pkg::OP_SRC_LATCH: begin
        c_q  <= src_data;
        hi_q <= hi;
      end
      jws_pkg::OP_HIT: begin
        if (sd_q) c2_q <= c_q;
        else      c1_q <= c_q;
      end
      jws_pkg::OP_ROUND: begin
        m_q <= m_q + 1'b1;
        if (c1_q != c2_q) t_q <= t_q + 1'b1;
      end
      jws_pkg::OP_ZERO: begin
        sim_q <= '0;
        m_q   <= '0;
        t_q   <= '0;
        pc_q  <= '0;
      end
      jws_pkg::OP_MUL1: begin
        t_q  <= t_q >> 1;
        mm_q <= MMW'(m_q) * MMW'(m_q);
        ab_q <= MMW'(l1_q) * MMW'(l2_q);
      end
      jws_pkg::OP_MUL2: begin
        s1_q <= NW'(mm_q) * NW'((LW + 1)'(l1_q) + (LW + 1)'(l2_q));
        s2_q <= NW'(LW'(m_q - t_q)) * NW'(ab_q);
        dn_q <= NW'(ab_q) * NW'(m_q);
      end
      jws_pkg::OP_MUL3: begin
        num_q <= s1_q + s2_q;
        den_q <= dn_q + (dn_q << 1);
      end
      jws_pkg::OP_SIM_J: sim_q <= quot[jws_pkg::SIM_W-1:0];
      jws_pkg::OP_IDX_CLR: pc_q <= '0;
      jws_pkg::OP_PFX_INC: pc_q <= pc_q + 1'b1;
      jws_pkg::OP_BMUL: prod_q <= PW'(pc_q) * PW'(jws_pkg::SIM_ONE - sim_q);
      jws_pkg::OP_DB_GO: bonus_q <= bprod[2*QW-1:jws_pkg::BONUS_SHIFT];
      jws_pkg::OP_BADD: begin
        // saturate at one
        sim_q <= (bsum > (BW + 1)'(jws_pkg::SIM_ONE)) ? jws_pkg::SIM_ONE
                                                      : bsum[jws_pkg::SIM_W-1:0];
      end
      default: ;
    endcase
  end

  assign pc_x  = XW'(pc_q);
  assign lim_x = XW'(limit_q);
  assign l1_x  = XW'(l1_q);
  assign l2_x  = XW'(l2_q);
  assign m_x   = XW'(m_q);
  assign t_x   = XW'(t_q);

  always_comb begin
    status_o.both_nonempty = (l1_q != '0) && (l2_q != '0);
    status_o.same_len      = (l1_q == l2_q);
    status_o.idx_lt_l1     = (idx_q < l1_q);
    status_o.rd_eq         = (rd1_q == rd2_q);
    status_o.sd            = sd_q;
    status_o.pos_end       = (pos >= slen);
    status_o.idx_ge_hi     = (idx_q >= hi_q);
    status_o.idx_used      = sd_q ? used1_q[idx_q[AW-1:0]] : used2_q[idx_q[AW-1:0]];
    status_o.dst_eq        = (dst_data == c_q);
    status_o.v1            = v1_q;
    status_o.v2            = v2_q;
    status_o.more          = (p1_q < l1_q) || (p2_q < l2_q);
    status_o.m_zero        = (m_q == '0);
    status_o.limit_zero    = (limit_q == '0);
    status_o.pfx_go        = (pc_x < lim_x) && (pc_x < l1_x) && (pc_x < l2_x);
    status_o.div_done      = div_done;
  end

  assign res_o = {ovf_q, pc_x[jws_pkg::PREFIX_W-1:0], t_x[jws_pkg::TRANS_W-1:0],
                  m_x[jws_pkg::MATCH_W-1:0], sim_q};

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (l1_q <= LW'(MAX_LEN)) && (l2_q <= LW'(MAX_LEN)))
    else $error("string length beyond capacity");

  a_clear_after_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == jws_pkg::OP_EMIT) |=> (l1_q == '0) && (l2_q == '0) && !ovf_q)
    else $error("strings not cleared after result");

  a_sim_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == jws_pkg::OP_EMIT) |-> (sim_q <= jws_pkg::SIM_ONE))
    else $error("similarity above one");

  a_match_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == jws_pkg::OP_SIM_J) |-> (m_q != '0) && (m_q <= l1_q) && (m_q <= l2_q))
    else $error("match count out of range at score");

endmodule

`default_nettype wire

// ===== rtl/jws_ctrl.sv =====
// Controller: state machine that sequences loads, match scan, the division and bonus.
// Depends on jws_pkg; drives jws_datapath through dp_cmd_t.
`timescale 1ns / 1ps
`default_nettype none

module jws_ctrl (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  input  wire logic [jws_pkg::OPC_W-1:0] opcode_i,
  input  wire logic                      out_free_i,
  input  wire jws_pkg::dp_status_t       status_i,
  output logic                           in_ready_o,
  output jws_pkg::dp_cmd_t               cmd_o
);

  typedef enum logic [21:0] {
    ST_IDLE     = 22'h000001,
    ST_START    = 22'h000002,
    ST_SAME_CHK = 22'h000004,
    ST_SAME_CMP = 22'h000008,
    ST_SC_SRC   = 22'h000010,
    ST_SC_SRCW  = 22'h000020,
    ST_SC_DST   = 22'h000040,
    ST_SC_CMP   = 22'h000080,
    ST_ROUND    = 22'h000100,
    ST_ROUND_NX = 22'h000200,
    ST_FIN      = 22'h000400,
    ST_MUL2     = 22'h000800,
    ST_MUL3     = 22'h001000,
    ST_DJ_GO    = 22'h002000,
    ST_DJ_W     = 22'h004000,
    ST_PFX_INIT = 22'h008000,
    ST_PFX_CHK  = 22'h010000,
    ST_PFX_CMP  = 22'h020000,
    ST_BMUL     = 22'h040000,
    ST_DB_GO    = 22'h080000,
    ST_DB_W     = 22'h100000,
    ST_EMIT     = 22'h200000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d   = state_q;
    cmd_o.op  = jws_pkg::OP_NONE;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          case (opcode_i)
            jws_pkg::OPC_FIRST, jws_pkg::OPC_SECOND: cmd_o.op = jws_pkg::OP_LOAD;
            jws_pkg::OPC_COMPUTE: begin
              cmd_o.op = jws_pkg::OP_INIT;
              state_d  = ST_START;
            end
            default: ;
          endcase
        end
      end
      ST_START: begin
        if (!status_i.both_nonempty) state_d = ST_EMIT;
        else if (status_i.same_len)  state_d = ST_SAME_CHK;
        else                         state_d = ST_SC_SRC;
      end
      ST_SAME_CHK: begin
        if (status_i.idx_lt_l1) begin
          cmd_o.op = jws_pkg::OP_RD_IDX;
          state_d  = ST_SAME_CMP;
        end else begin
          cmd_o.op = jws_pkg::OP_SAME;
          state_d  = ST_EMIT;
        end
      end
      ST_SAME_CMP: begin
        if (status_i.rd_eq) begin
          cmd_o.op = jws_pkg::OP_IDX_INC;
          state_d  = ST_SAME_CHK;
        end else begin
          state_d  = ST_SC_SRC;
        end
      end
      ST_SC_SRC: begin
        if (status_i.pos_end) begin
          cmd_o.op = jws_pkg::OP_SIDE_DONE;
          state_d  = status_i.sd ? ST_ROUND : ST_SC_SRC;
        end else begin
          cmd_o.op = jws_pkg::OP_SRC_RD;
          state_d  = ST_SC_SRCW;
        end
      end
      ST_SC_SRCW: begin
        cmd_o.op = jws_pkg::OP_SRC_LATCH;
        state_d  = ST_SC_DST;
      end
      ST_SC_DST: begin
        if (status_i.idx_ge_hi) begin
          // window exhausted: advance to the next source character
          cmd_o.op = jws_pkg::OP_POS_INC;
          state_d  = ST_SC_SRC;
        end else if (status_i.idx_used) begin
          cmd_o.op = jws_pkg::OP_IDX_INC;
        end else begin
          cmd_o.op = jws_pkg::OP_DST_RD;
          state_d  = ST_SC_CMP;
        end
      end
      ST_SC_CMP: begin
        if (status_i.dst_eq) begin
          cmd_o.op = jws_pkg::OP_HIT;
          state_d  = status_i.sd ? ST_ROUND : ST_SC_SRC;
        end else begin
          cmd_o.op = jws_pkg::OP_IDX_INC;
          state_d  = ST_SC_DST;
        end
      end
      ST_ROUND: begin
        if (!status_i.v1 && !status_i.v2) begin
          state_d = ST_FIN;
        end else if (status_i.v1 != status_i.v2) begin
          // one-sided round: drop everything
          cmd_o.op = jws_pkg::OP_ZERO;
          state_d  = ST_EMIT;
        end else begin
          cmd_o.op = jws_pkg::OP_ROUND;
          state_d  = ST_ROUND_NX;
        end
      end
      ST_ROUND_NX: state_d = status_i.more ? ST_SC_SRC : ST_FIN;
      ST_FIN: begin
        if (status_i.m_zero) begin
          cmd_o.op = jws_pkg::OP_ZERO;
          state_d  = ST_EMIT;
        end else begin
          cmd_o.op = jws_pkg::OP_MUL1;
          state_d  = ST_MUL2;
        end
      end
      ST_MUL2: begin
        cmd_o.op = jws_pkg::OP_MUL2;
        state_d  = ST_MUL3;
      end
      ST_MUL3: begin
        cmd_o.op = jws_pkg::OP_MUL3;
        state_d  = ST_DJ_GO;
      end
      ST_DJ_GO: begin
        cmd_o.op = jws_pkg::OP_DJ_GO;
        state_d  = ST_DJ_W;
      end
      ST_DJ_W: begin
        if (status_i.div_done) begin
          cmd_o.op = jws_pkg::OP_SIM_J;
          state_d  = status_i.limit_zero ? ST_EMIT : ST_PFX_INIT;
        end
      end
      ST_PFX_INIT: begin
        cmd_o.op = jws_pkg::OP_IDX_CLR;
        state_d  = ST_PFX_CHK;
      end
      ST_PFX_CHK: begin
        if (status_i.pfx_go) begin
          cmd_o.op = jws_pkg::OP_RD_IDX;
          state_d  = ST_PFX_CMP;
        end else begin
          state_d  = ST_BMUL;
        end
      end
      ST_PFX_CMP: begin
        if (status_i.rd_eq) begin
          cmd_o.op = jws_pkg::OP_PFX_INC;
          state_d  = ST_PFX_CHK;
        end else begin
          state_d  = ST_BMUL;
        end
      end
      ST_BMUL: begin
        cmd_o.op = jws_pkg::OP_BMUL;
        state_d  = ST_DB_GO;
      end
      ST_DB_GO: begin
        cmd_o.op = jws_pkg::OP_DB_GO;
        state_d  = ST_DB_W;
      end
      ST_DB_W: begin
        cmd_o.op = jws_pkg::OP_BADD;
        state_d  = ST_EMIT;
      end
      ST_EMIT: begin
        // hold until the output register can take the beat
        if (out_free_i) begin
          cmd_o.op = jws_pkg::OP_EMIT;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ===== tb/sv/jws_checker.sv =====
// Scoreboard for the Jaro-Winkler similarity block: watches the input, configuration
// and result channels, predicts each score and compares it field by field.
// Depends on jws_pkg for the opcodes and field widths.
`timescale 1ns / 1ps

module jws_checker (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_tvalid_i,
  input  logic                               s_tready_i,
  input  logic [jws_pkg::IN_TDATA_W-1:0]     s_tdata_i,
  input  logic [jws_pkg::OPC_W-1:0]          s_tuser_i,
  input  logic                               m_tvalid_i,
  input  logic                               m_tready_i,
  input  logic [jws_pkg::OUT_TDATA_W-1:0]    m_tdata_i,
  input  logic                               cfg_valid_i,
  input  logic                               cfg_ready_i,
  input  logic [jws_pkg::LIMIT_W-1:0]        cfg_data_i,
  output int unsigned                        err_count_o,
  output int unsigned                        pending_o,
  output int unsigned                        scores_seen_o
);

  localparam int DEPTH = 64;

  typedef struct {
    logic [jws_pkg::SIM_W-1:0]    sim;
    logic [jws_pkg::MATCH_W-1:0]  match_n;
    logic [jws_pkg::TRANS_W-1:0]  transp;
    logic [jws_pkg::PREFIX_W-1:0] pfx;
    logic                         ovf;
  } score_t;

  logic [jws_pkg::CHAR_W-1:0]  str_q [2][DEPTH];
  int                          len_q [2];
  logic                        ovf_q;
  logic [jws_pkg::LIMIT_W-1:0] limit_q;
  score_t                      scores_pending [$];

  assign pending_o = scores_pending.size();

  task automatic report(input string what, input longint unsigned got,
                        input longint unsigned want);
    err_count_o++;
    $display("[%0t] mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
  endtask

  function automatic score_t score_strings();
    score_t                     r;
    longint unsigned            sim, m, t, pc, a, b, num, den;
    int                         l1, l2, h, p, lo, hi, i, s;
    int                         pos [2];
    logic [jws_pkg::CHAR_W-1:0] got [2];
    bit                         hit [2];
    bit                         same, aborted;
    logic [DEPTH-1:0]           used [2];
    sim = 0; m = 0; t = 0; pc = 0;
    l1 = len_q[0]; l2 = len_q[1];
    pos[0] = 0; pos[1] = 0; used[0] = '0; used[1] = '0;
    aborted = 0;
    if (l1 != 0 && l2 != 0) begin
      same = (l1 == l2);
      for (i = 0; same && i < l1; i++)
        if (str_q[0][i] != str_q[1][i]) same = 0;
      if (same) begin
        sim = 65536;
        m = l1;
      end else begin
        h = (l1 / 2 < l2 / 2) ? l1 / 2 + 1 : l2 / 2 + 1;
        while (pos[0] < l1 || pos[1] < l2) begin
          // side 0 scans the first string against the second, side 1 the reverse
          for (s = 0; s < 2; s++) begin
            hit[s] = 0;
            got[s] = '0;
            while (!hit[s] && pos[s] < len_q[s]) begin
              p = pos[s];
              lo = (h > p) ? 0 : p - h;
              hi = (p + h > len_q[1-s]) ? len_q[1-s] : p + h;
              for (i = lo; i < hi && !hit[s]; i++)
                if (!used[s][i] && str_q[s][p] == str_q[1-s][i]) begin
                  got[s] = str_q[1-s][i];
                  used[s][i] = 1'b1;
                  hit[s] = 1;
                end
              pos[s] = p + 1;
            end
          end
          if (!hit[0] && !hit[1]) break;
          if (hit[0] != hit[1]) begin
            aborted = 1;
            break;
          end
          m++;
          if (got[0] != got[1]) t++;
        end
        if (aborted || m == 0) begin
          m = 0;
          t = 0;
        end else begin
          a = l1; b = l2;
          t = t / 2;
          num = m * m * b + m * m * a + (m - t) * a * b;
          den = 3 * a * b * m;
          sim = (num * 65536) / den;
          if (limit_q != 0) begin
            while (pc < limit_q && pc < l1 && pc < l2 && str_q[0][pc] == str_q[1][pc])
              pc++;
            sim = sim + (pc * (65536 - sim)) / 10;
            if (sim > 65536) sim = 65536;
          end
        end
      end
    end
    r.sim = sim[jws_pkg::SIM_W-1:0];
    r.match_n = m[jws_pkg::MATCH_W-1:0];
    r.transp = t[jws_pkg::TRANS_W-1:0];
    r.pfx = pc[jws_pkg::PREFIX_W-1:0];
    r.ovf = ovf_q;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    score_t want;
    int     side;
    if (!rst_ni) begin
      len_q[0] = 0;
      len_q[1] = 0;
      ovf_q = 0;
      limit_q = '0;
      scores_pending.delete();
      err_count_o = 0;
      scores_seen_o = 0;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        scores_seen_o++;
        if (scores_pending.size() == 0) begin
          err_count_o++;
          $display("[%0t] unexpected result beat %h", $realtime, m_tdata_i);
        end else begin
          want = scores_pending.pop_front();
          if (m_tdata_i[16:0] != want.sim) report("similarity", m_tdata_i[16:0], want.sim);
          if (m_tdata_i[23:17] != want.match_n)
            report("match_count", m_tdata_i[23:17], want.match_n);
          if (m_tdata_i[29:24] != want.transp)
            report("transposition_count", m_tdata_i[29:24], want.transp);
          if (m_tdata_i[36:30] != want.pfx) report("prefix_count", m_tdata_i[36:30], want.pfx);
          if (m_tdata_i[37] != want.ovf) report("overflow", m_tdata_i[37], want.ovf);
        end
      end
      if (cfg_valid_i && cfg_ready_i) limit_q = cfg_data_i;
      if (s_tvalid_i && s_tready_i) begin
        case (s_tuser_i)
          jws_pkg::OPC_FIRST, jws_pkg::OPC_SECOND: begin
            side = (s_tuser_i == jws_pkg::OPC_FIRST) ? 0 : 1;
            if (len_q[side] < DEPTH) begin
              str_q[side][len_q[side]] = s_tdata_i[jws_pkg::CHAR_W-1:0];
              len_q[side]++;
            end else begin
              ovf_q = 1;
            end
          end
          jws_pkg::OPC_COMPUTE: begin
            scores_pending.push_back(score_strings());
            len_q[0] = 0;
            len_q[1] = 0;
            ovf_q = 0;
          end
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== tb/sv/jaro_winkler_similarity_tb.sv =====
// Top of the Jaro-Winkler similarity testbench: clock, reset, string stimulus,
// result back-pressure and the verdict. Depends on jws_pkg, jws_checker and the block.
`timescale 1ns / 1ps

module jaro_winkler_similarity_tb;

  logic                            clk_i = 0;
  logic                            rst_ni = 0;
  logic                            s_axis_tvalid = 0;
  logic                            s_axis_tready;
  logic [jws_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic [jws_pkg::OPC_W-1:0]       s_axis_tuser = jws_pkg::OPC_FIRST;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 0;
  logic [jws_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
  logic                            cfg_valid_i = 0;
  logic                            cfg_ready_o;
  logic [jws_pkg::LIMIT_W-1:0]     cfg_data_i = '0;

  int unsigned err_count, pending, scores_seen;
  int          tx_idle_pct = 0;
  int          rx_idle_pct = 0;
  int          beats_sent = 0;
  bit          long_hold_req = 0;
  bit          long_hold_done = 0;
  int          hold_left = 0;

  int          str_a [70];
  int          str_b [70];
  int          len_a, len_b;

  always #5 clk_i = ~clk_i;

  jaro_winkler_similarity u_top (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i
  );

  jws_checker u_checker (
    .clk_i, .rst_ni,
    .s_tvalid_i(s_axis_tvalid), .s_tready_i(s_axis_tready),
    .s_tdata_i(s_axis_tdata), .s_tuser_i(s_axis_tuser),
    .m_tvalid_i(m_axis_tvalid), .m_tready_i(m_axis_tready), .m_tdata_i(m_axis_tdata),
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_data_i,
    .err_count_o(err_count), .pending_o(pending), .scores_seen_o(scores_seen)
  );

  // Result side: random back-pressure, plus one long hold-off on request
  always @(posedge clk_i) begin
    if (long_hold_req && !long_hold_done) begin
      long_hold_done = 1;
      hold_left = 3000;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= rst_ni && ($urandom_range(99) >= rx_idle_pct);
    end
  end

  initial begin
    #100_000_000;
    $display("** jaro_winkler_similarity: FAILED **");
    $finish;
  end

  task automatic send_beat(input logic [jws_pkg::OPC_W-1:0] op, input int ch);
    if ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {3'b000, ch[jws_pkg::CHAR_W-1:0]};
    do @(posedge clk_i); while (!s_axis_tready);
    if (op != jws_pkg::OPC_RSVD) beats_sent++;
  endtask

  // Hold the input until every score is back, then let the block settle
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic set_limit(input int lim);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= lim[jws_pkg::LIMIT_W-1:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // Load both strings in a random interleave, with some unused-opcode noise, then score
  task automatic send_pair();
    int ia, ib;
    ia = 0; ib = 0;
    while (ia < len_a || ib < len_b) begin
      if ($urandom_range(99) < 3) send_beat(jws_pkg::OPC_RSVD, $urandom_range(0, 2097151));
      if (ib >= len_b || (ia < len_a && $urandom_range(1) == 0)) begin
        send_beat(jws_pkg::OPC_FIRST, str_a[ia]);
        ia++;
      end else begin
        send_beat(jws_pkg::OPC_SECOND, str_b[ib]);
        ib++;
      end
    end
    send_beat(jws_pkg::OPC_COMPUTE, $urandom_range(0, 2097151));
  endtask

  function automatic int rand_char();
    int r;
    r = $urandom_range(99);
    if (r < 80) return 97 + $urandom_range(0, 4);
    if (r < 90) return $urandom_range(0, 3);
    return $urandom_range(0, 2097151);
  endfunction

  task automatic random_pair();
    int r, i, j, tmp;
    r = $urandom_range(99);
    len_a = (r < 4) ? $urandom_range(60, 66) : $urandom_range(0, 9);
    for (i = 0; i < len_a; i++) str_a[i] = rand_char();
    if ($urandom_range(99) < 65) begin
      // near copy: swap, change, trim or extend
      len_b = len_a;
      for (i = 0; i < len_a; i++) str_b[i] = str_a[i];
      for (j = $urandom_range(0, 2); j > 0; j--) begin
        r = $urandom_range(3);
        i = (len_b > 0) ? $urandom_range(0, len_b - 1) : 0;
        if (r == 0 && i + 1 < len_b) begin
          tmp = str_b[i]; str_b[i] = str_b[i+1]; str_b[i+1] = tmp;
        end else if (r == 1 && len_b > 0) begin
          str_b[i] = rand_char();
        end else if (r == 2 && len_b > 0) begin
          len_b--;
        end else if (len_b < 70) begin
          str_b[len_b] = rand_char();
          len_b++;
        end
      end
    end else begin
      len_b = (len_a > 20) ? $urandom_range(55, 66) : $urandom_range(0, 9);
      for (i = 0; i < len_b; i++) str_b[i] = rand_char();
    end
    send_pair();
  endtask

  initial begin
    int seg, target, i;
    int limits [7] = '{4, 64, 0, 10, 1, 11, 63};
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty strings, one empty side, extreme codes, no overlap, a transposed pair, overflow
    len_a = 0; len_b = 0; send_pair();
    len_a = 1; str_a[0] = 97; len_b = 0; send_pair();
    len_a = 0; len_b = 2; str_b[0] = 0; str_b[1] = 2097151; send_pair();
    len_a = 2; str_a[0] = 0; str_a[1] = 2097151;
    len_b = 2; str_b[0] = 0; str_b[1] = 2097151; send_pair();
    len_a = 2; str_a[0] = 97; str_a[1] = 98;
    len_b = 2; str_b[0] = 99; str_b[1] = 100; send_pair();
    len_a = 3; str_a[0] = 97; str_a[1] = 98; str_a[2] = 99;
    len_b = 3; str_b[0] = 98; str_b[1] = 97; str_b[2] = 99; send_pair();
    send_beat(jws_pkg::OPC_RSVD, 2097151);
    len_a = 66; len_b = 1;
    for (i = 0; i < 66; i++) str_a[i] = 97 + (i % 3);
    str_b[0] = 98; send_pair();

    for (seg = 0; seg < 7; seg++) begin
      set_limit(limits[seg]);
      if (seg == 1) long_hold_req <= 1'b1;
      target = (seg + 1) * 150;
      while (beats_sent < target) begin
        if (beats_sent < 400) begin
          tx_idle_pct = 38; rx_idle_pct = 72;
        end else if (beats_sent < 750) begin
          tx_idle_pct = 72; rx_idle_pct = 38;
        end else begin
          tx_idle_pct = 0; rx_idle_pct = 0;
        end
        random_pair();
      end
    end

    s_axis_tvalid <= 1'b0;
    i = 0;
    while (pending != 0 && i < 2_000_000) begin
      @(posedge clk_i);
      i++;
    end
    repeat (200) @(posedge clk_i);
    $display("Sent %0d load/score beats over 7 bonus limits (0 to 64), checked %0d scores,",
             beats_sent, scores_seen);
    $display("with empty, identical, disjoint, overflowing and random near-copy strings.");
    if (err_count == 0 && pending == 0) begin
      $display("** jaro_winkler_similarity: PASSED **");
    end else begin
      $display("** jaro_winkler_similarity: FAILED **");
    end
    $finish;
  end

endmodule
